### rtl/pvpfd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// PC video pixel fetch/decode package
// Shared widths, codes and constants for the pixel fetch/decode block.
// ============================================================================
package pvpfd_pkg;

    // RAM window and VRAM plane geometry.
    localparam int WIN_AW       = 17;
    localparam int WINDOW_BYTES = 2 ** WIN_AW;
    localparam int PLANE_AW     = 16;
    localparam int PLANE_BYTES  = 2 ** PLANE_AW;
    localparam int NUM_PLANES   = 4;

    // Field widths of one input item and one result item.
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 17;
    localparam int PLANE_W = 2;
    localparam int DATA_W  = 8;
    localparam int X_W     = 10;
    localparam int Y_W     = 9;
    localparam int COLOR_W = 8;

    // Stream bus widths: tdata packed from the lowest bit, padded to bytes.
    localparam int IN_BITS    = ADDR_W + PLANE_W + DATA_W + X_W + Y_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((COLOR_W + 7) / 8) * 8;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // The PCjr/Tandy display sits at the fixed CGA segment within the window.
    localparam logic [WIN_AW-1:0] PCJR_BASE = WIN_AW'(32'hB8000 % WINDOW_BYTES);

    // Reset value of the display base register.
    localparam logic [WIN_AW-1:0] VIDEO_BASE_RST = WIN_AW'(98304);

    // Kind of an input item, carried on tuser.
    typedef enum logic [MODE_W-1:0] {
        IN_WR_WIN   = 2'd0,
        IN_WR_PLANE = 2'd1,
        IN_PIXEL    = 2'd2
    } t_in_mode;

    // Display modes.
    typedef enum logic [3:0] {
        DM_CGA4    = 4'd0,
        DM_CGAGREY = 4'd1,
        DM_CGAMONO = 4'd2,
        DM_HERC    = 4'd3,
        DM_PCJR    = 4'd4,
        DM_TANDY   = 4'd5,
        DM_EGA320  = 4'd6,
        DM_EGA350  = 4'd7,
        DM_VGA480  = 4'd8,
        DM_VGA256  = 4'd9
    } t_disp_mode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISPLAY_MODE  = 3'd0,
        CFG_VIDEO_BASE    = 3'd1,
        CFG_PALETTE_SEL   = 3'd2,
        CFG_INTENSITY     = 3'd3,
        CFG_BACKGROUND    = 3'd4,
        CFG_PAGE_OFFSET   = 3'd5,
        CFG_PLANAR_SELECT = 3'd6,
        CFG_PIXEL_PAN     = 3'd7
    } t_cfg_idx;

endpackage

### rtl/pvpfd_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// Generic RAM
// One write port and one read port; read data is registered and holds
// its value in cycles without a read.
// ============================================================================
module pvpfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pc_video_pixel_fetch_decode.sv
`timescale 1ns / 1ps
// ============================================================================
// PC video pixel fetch/decode
// Holds a system-RAM video window and four VRAM planes and decodes one
// color index per pixel request for the CGA, Hercules, PCjr/Tandy, EGA and
// VGA graphics modes.
// ============================================================================
// Usage:
// - The slave stream carries one item per transaction. tuser gives its kind:
//   a RAM window write, a VRAM plane write or a pixel request. Writes take
//   effect at the accepting edge and return nothing; a pixel request returns
//   one color index on the master stream.
// - The configuration channel writes one register per transaction; it is
//   always ready and is to be used only while no pixel request is in flight.
// - A pixel request's address is formed in the accepting cycle and latched
//   by the memories at the accepting edge; the read stage then holds it until
//   the output register is free, and the decoded color lands there.
// - Throughput: one item per cycle while not stalled, reads and writes mixed
//   in any order. The window RAM and the four plane RAMs each give one
//   access per cycle.
// - When the receiver stalls, the output register and the read stage hold;
//   one more request is still taken while the result waits, then tready
//   drops until the output register is freed.
// - Reset clears the pipeline and the registers (display base 98304, all
//   else zero). Memory contents are not cleared; unwritten bytes read as
//   unknown.
// ============================================================================
module pc_video_pixel_fetch_decode (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Slave stream. tdata, from bit 0: address[16:0], plane[18:17],
    // data[26:19], x[36:27], y[45:37], zero fill[47:46].
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pvpfd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser, from bit 0: mode[1:0].
    input  logic [pvpfd_pkg::MODE_W-1:0]        s_axis_tuser,
    // Master stream. tdata, from bit 0: color[7:0].
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pvpfd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pvpfd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pvpfd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int WA = pvpfd_pkg::WIN_AW;
    localparam int PA = pvpfd_pkg::PLANE_AW;

    // Configuration registers.
    logic [3:0]                      r_display_mode;
    logic [WA-1:0]                   r_video_base;
    logic                            r_palette_sel;
    logic                            r_intensity;
    logic [pvpfd_pkg::COLOR_W-1:0]   r_background;
    logic [PA-1:0]                   r_page_offset;
    logic                            r_planar_select;
    logic [3:0]                      r_pixel_pan;

    // Unpacked input fields.
    logic [pvpfd_pkg::ADDR_W-1:0]    in_address;
    logic [pvpfd_pkg::PLANE_W-1:0]   in_plane;
    logic [pvpfd_pkg::DATA_W-1:0]    in_data;
    logic [pvpfd_pkg::X_W-1:0]       in_x;
    logic [pvpfd_pkg::Y_W-1:0]       in_y;

    // Handshake and pipeline control.
    logic                            in_accept;
    logic                            pix_accept;
    logic                            win_we;
    logic                            s1_adv;
    logic                            r_s1_valid;
    logic                            n_s1_valid;
    logic [2:0]                      r_s1_x;
    logic                            r_out_valid;
    logic                            n_out_valid;
    logic [pvpfd_pkg::COLOR_W-1:0]   r_out_color;
    logic [pvpfd_pkg::COLOR_W-1:0]   n_out_color;

    // Read addresses and data.
    logic [WA-1:0]                   win_raddr;
    logic [PA-1:0]                   pl_raddr;
    logic [pvpfd_pkg::DATA_W-1:0]    win_rdata;
    logic [pvpfd_pkg::DATA_W-1:0]    pl_rdata [pvpfd_pkg::NUM_PLANES];

    // Address terms.
    logic [17:0]                     y320;
    logic [17:0]                     lin_pix;
    logic [15:0]                     vga_row;

    // Decode terms.
    logic [1:0]                      cga_v;
    logic                            mono_bit;
    logic [3:0]                      four_c;
    logic [pvpfd_pkg::DATA_W-1:0]    planar_byte;

    assign in_address = s_axis_tdata[16:0];
    assign in_plane   = s_axis_tdata[18:17];
    assign in_data    = s_axis_tdata[26:19];
    assign in_x       = s_axis_tdata[36:27];
    assign in_y       = s_axis_tdata[45:37];

    // Configuration register writes.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_mode  <= pvpfd_pkg::DM_CGA4;
            r_video_base    <= pvpfd_pkg::VIDEO_BASE_RST;
            r_palette_sel   <= 1'b0;
            r_intensity     <= 1'b0;
            r_background    <= '0;
            r_page_offset   <= '0;
            r_planar_select <= 1'b0;
            r_pixel_pan     <= '0;
        end else if (i_cfg_valid) begin
            case (pvpfd_pkg::t_cfg_idx'(i_cfg_index))
                pvpfd_pkg::CFG_DISPLAY_MODE:  r_display_mode  <= i_cfg_data[3:0];
                pvpfd_pkg::CFG_VIDEO_BASE:    r_video_base    <= i_cfg_data[WA-1:0];
                pvpfd_pkg::CFG_PALETTE_SEL:   r_palette_sel   <= i_cfg_data[0];
                pvpfd_pkg::CFG_INTENSITY:     r_intensity     <= i_cfg_data[0];
                pvpfd_pkg::CFG_BACKGROUND:    r_background    <= i_cfg_data[7:0];
                pvpfd_pkg::CFG_PAGE_OFFSET:   r_page_offset   <= i_cfg_data[PA-1:0];
                pvpfd_pkg::CFG_PLANAR_SELECT: r_planar_select <= i_cfg_data[0];
                pvpfd_pkg::CFG_PIXEL_PAN:     r_pixel_pan     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Handshake: the read stage moves on when the output register is free.
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign pix_accept    = in_accept && (s_axis_tuser == pvpfd_pkg::IN_PIXEL);
    assign win_we        = in_accept && (s_axis_tuser == pvpfd_pkg::IN_WR_WIN);

    // Shared products of the row number; y times 320 needs 18 bits.
    assign y320    = 18'({in_y, 8'b0}) + 18'({in_y, 6'b0});
    assign lin_pix = y320 + 18'(in_x);
    assign vga_row = r_page_offset + y320[15:0];

    // RAM window read address for the requested pixel.
    always_comb begin
        case (r_display_mode)
            pvpfd_pkg::DM_CGA4, pvpfd_pkg::DM_CGAGREY: begin
                win_raddr = r_video_base + WA'({in_y[8:1], 6'b0})
                          + WA'({in_y[8:1], 4'b0}) + WA'({in_y[0], 13'b0})
                          + WA'(in_x[9:2]);
            end
            pvpfd_pkg::DM_CGAMONO: begin
                win_raddr = r_video_base + WA'({in_y[8:2], 6'b0})
                          + WA'({in_y[8:2], 4'b0}) + WA'({in_y[1], 13'b0})
                          + WA'(in_x[9:3]);
            end
            pvpfd_pkg::DM_HERC: begin
                win_raddr = r_video_base + WA'({in_y[1:0], 13'b0})
                          + WA'({in_y[8:2], 6'b0}) + WA'({in_y[8:2], 4'b0})
                          + WA'({in_y[8:2], 3'b0}) + WA'({in_y[8:2], 1'b0})
                          + WA'(in_x[9:3]);
            end
            pvpfd_pkg::DM_PCJR: begin
                win_raddr = pvpfd_pkg::PCJR_BASE + WA'({in_y[8:2], 6'b0})
                          + WA'({in_y[8:2], 4'b0}) + WA'(in_x[9:3])
                          + WA'({in_y[1], 13'b0});
            end
            pvpfd_pkg::DM_TANDY: begin
                win_raddr = pvpfd_pkg::PCJR_BASE + WA'({in_y[8:3], 7'b0})
                          + WA'({in_y[8:3], 5'b0}) + WA'(in_x[9:2])
                          + WA'({in_y[2:1], 13'b0});
            end
            default: begin
                win_raddr = r_video_base + WA'(vga_row) + WA'(in_x);
            end
        endcase
    end

    // Plane read address for the requested pixel.
    always_comb begin
        case (r_display_mode)
            pvpfd_pkg::DM_EGA320: begin
                pl_raddr = PA'({in_y, 5'b0}) + PA'({in_y, 3'b0}) + PA'(in_x[9:3]);
            end
            pvpfd_pkg::DM_EGA350, pvpfd_pkg::DM_VGA480: begin
                pl_raddr = PA'({in_y, 6'b0}) + PA'({in_y, 4'b0}) + PA'(in_x[9:3]);
            end
            default: begin
                pl_raddr = PA'(lin_pix[17:2]) + r_page_offset - PA'(r_pixel_pan);
            end
        endcase
    end

    // RAM window store.
    pvpfd_ram #(
        .WIDTH (pvpfd_pkg::DATA_W),
        .DEPTH (pvpfd_pkg::WINDOW_BYTES)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (in_address[WA-1:0]),
        .i_wdata (in_data),
        .i_re    (pix_accept),
        .i_raddr (win_raddr),
        .o_rdata (win_rdata)
    );

    // VRAM planes, all read at one address so that a four-plane pixel
    // gathers its bits in a single access.
    for (genvar g = 0; g < pvpfd_pkg::NUM_PLANES; g++) begin : g_plane
        logic pl_we;

        assign pl_we = in_accept && (s_axis_tuser == pvpfd_pkg::IN_WR_PLANE)
                    && (in_plane == pvpfd_pkg::PLANE_W'(g));

        pvpfd_ram #(
            .WIDTH (pvpfd_pkg::DATA_W),
            .DEPTH (pvpfd_pkg::PLANE_BYTES)
        ) u_plane_ram (
            .i_clk   (i_clk),
            .i_we    (pl_we),
            .i_waddr (in_address[PA-1:0]),
            .i_wdata (in_data),
            .i_re    (pix_accept),
            .i_raddr (pl_raddr),
            .o_rdata (pl_rdata[g])
        );
    end

    // Read stage: remembers the pixel column bits needed for decoding.
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (pix_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_accept) begin
            r_s1_x <= in_x[2:0];
        end
    end

    // Bit and field selection from the fetched bytes.
    always_comb begin
        case (r_s1_x[1:0])
            2'd0:    cga_v = win_rdata[7:6];
            2'd1:    cga_v = win_rdata[5:4];
            2'd2:    cga_v = win_rdata[3:2];
            default: cga_v = win_rdata[1:0];
        endcase
        mono_bit    = win_rdata[~r_s1_x];
        four_c      = {pl_rdata[3][~r_s1_x], pl_rdata[2][~r_s1_x],
                       pl_rdata[1][~r_s1_x], pl_rdata[0][~r_s1_x]};
        planar_byte = pl_rdata[r_s1_x[1:0]];
    end

    // Color decode per display mode.
    always_comb begin
        case (r_display_mode)
            pvpfd_pkg::DM_CGA4: begin
                if (cga_v == 2'd0) begin
                    n_out_color = r_background;
                end else begin
                    n_out_color = 8'({r_intensity, cga_v, r_palette_sel});
                end
            end
            pvpfd_pkg::DM_CGAGREY: begin
                n_out_color = 8'({cga_v, 6'b0}) - 8'(cga_v);
            end
            pvpfd_pkg::DM_CGAMONO, pvpfd_pkg::DM_HERC: begin
                n_out_color = mono_bit ? 8'd15 : 8'd0;
            end
            pvpfd_pkg::DM_PCJR, pvpfd_pkg::DM_TANDY: begin
                n_out_color = r_s1_x[1] ? 8'(win_rdata[3:0]) : 8'(win_rdata[7:4]);
            end
            pvpfd_pkg::DM_EGA320, pvpfd_pkg::DM_EGA350, pvpfd_pkg::DM_VGA480: begin
                n_out_color = 8'(four_c);
            end
            pvpfd_pkg::DM_VGA256: begin
                n_out_color = r_planar_select ? planar_byte : win_rdata;
            end
            default: begin
                n_out_color = '0;
            end
        endcase
    end

    // Output register.
    always_comb begin
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_color <= n_out_color;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = pvpfd_pkg::OUT_TDATA_W'(r_out_color);

endmodule

### rtl/pvpfd_chk.sv
`timescale 1ns / 1ps
// ============================================================================
// PC video pixel fetch/decode checker
// Port-level assertions on the pixel fetch/decode block, bound to its top.
// ============================================================================
module pvpfd_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [pvpfd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input logic [pvpfd_pkg::MODE_W-1:0]        s_axis_tuser,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [pvpfd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic pix_transaction;

    assign pix_transaction = s_axis_tvalid && s_axis_tready
                          && (s_axis_tuser == pvpfd_pkg::IN_PIXEL);

    // A result that is not taken stays offered with the same value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    // With nothing waiting at the output, the input side is ready.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    // A pixel request is offered once it has passed the read stage into the
    // output register, if the output flows while it sits in the read stage.
    a_pixel_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_transaction ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("pixel result missing after request");

endmodule

bind pc_video_pixel_fetch_decode pvpfd_chk u_pvpfd_chk (.*);
